// ----- src/fcm_pkg.sv -----
package fcm_pkg;

  // default model shape
  localparam int unsigned OrderDef     = 2;
  localparam int unsigned AlphabetDef  = 27;
  localparam int unsigned CountBitsDef = 16;

  // fixed field widths
  localparam int unsigned SymW    = 5;
  localparam int unsigned AlphaW  = 16;
  localparam int unsigned CostW   = 21;
  localparam int unsigned SumW    = 48;
  localparam int unsigned CntW    = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned AlphaQ  = 12;  // alpha is Q4.12, counts scale by 4096
  localparam int unsigned MantW   = 32;  // Q1.31 mantissa

  localparam logic [AlphaW-1:0] AlphaReset = 16'd4096;
  localparam logic [CostW-1:0]  CostMax    = {CostW{1'b1}};

  // input kinds
  localparam logic OpTrain    = 1'b0;
  localparam logic OpEstimate = 1'b1;

  // main sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_LOG_NUM,
    ST_LOG_DEN,
    ST_RESULT
  } fcm_state_e;

  // log2 unit sequencer
  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } fcm_log_state_e;

endpackage

// ----- src/fcm_ram.sv -----
module fcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fcm_log2.sv -----
module fcm_log2 #(
  parameter int unsigned XW = 34
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [XW-1:0]                         x_i,
  output logic                                  done_o,
  output logic [$clog2(XW)+fcm_pkg::FracW-1:0] l_o
);

  localparam int unsigned EW = $clog2(XW);
  localparam int unsigned MW = fcm_pkg::MantW;

  fcm_pkg::fcm_log_state_e state_q, state_d;
  logic [XW-1:0]              x_q, x_d;
  logic [EW-1:0]              e_q, e_d;
  logic [MW-1:0]              m_q, m_d;
  logic [fcm_pkg::FracW-1:0]  f_q, f_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic [2*MW-1:0]            sq;
  logic [MW:0]                sq_top;
  logic [XW+MW-1:0]           x_ext;

  assign x_ext  = {x_q, {MW{1'b0}}};
  assign sq     = m_q * m_q;
  assign sq_top = sq[2*MW-1:MW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcm_pkg::LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    e_q   <= e_d;
    m_q   <= m_d;
    f_q   <= f_d;
    cnt_q <= cnt_d;
  end

  // normalize one bit a cycle, then one squaring a cycle per fraction bit
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    e_d     = e_q;
    m_d     = m_q;
    f_d     = f_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      fcm_pkg::LG_IDLE: begin
        if (start_i) begin
          x_d     = x_i;
          e_d     = EW'(XW - 1);
          state_d = fcm_pkg::LG_NORM;
        end
      end
      fcm_pkg::LG_NORM: begin
        if (x_q[XW-1] || (x_q == '0)) begin
          m_d     = x_ext[XW+MW-1:XW];
          f_d     = '0;
          cnt_d   = '0;
          state_d = fcm_pkg::LG_SQR;
        end else begin
          x_d = {x_q[XW-2:0], 1'b0};
          e_d = e_q - 1'b1;
        end
      end
      fcm_pkg::LG_SQR: begin
        f_d = {f_q[fcm_pkg::FracW-2:0], sq_top[MW]};
        m_d = sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(fcm_pkg::FracW - 1)) begin
          done_d  = 1'b1;
          state_d = fcm_pkg::LG_IDLE;
        end
      end
      default: state_d = fcm_pkg::LG_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign l_o    = {e_q, f_q};

endmodule

// ----- src/finite_context_model_cost_unit.sv -----
// channel  | dir | tdata (low bit up)                              | tuser
// s_axis   | in  | symbol[4:0], zero pad to 8                      | operation, first
// m_axis   | out | symbol_cost[20:0], cost_sum[68:21],             | coded
//          |     | coded_count[100:69], zero pad to 104            |
// cfg      | in  | smoothing_alpha, written when cfg_we_i is high  | -
//
// one item at a time; s_axis_tready is low from acceptance to the end of its work
// train item or zero numerator: through READ and UPDATE, as the table reads are registered;
// history fill or ignored symbol: straight to RESULT
// estimate: through READ and UPDATE, then the log2 of each operand, normalizing out its leading zeros
// one bit a cycle through the shared log2 unit, then 16 squarings on its multiplier
// after reset both tables are cleared, one entry a cycle, ALPHABET**(ORDER+1) entries
// (19683 at defaults) before the first transfer is accepted; a stalled m_axis holds
// the finished result and the next item waits in the result stage
module finite_context_model_cost_unit #(
  parameter int unsigned ORDER      = fcm_pkg::OrderDef,
  parameter int unsigned ALPHABET   = fcm_pkg::AlphabetDef,
  parameter int unsigned COUNT_BITS = fcm_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // symbol
  input  logic [1:0]                  s_axis_tuser,   // operation, first
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [103:0]                m_axis_tdata,   // symbol_cost, cost_sum, coded_count
  output logic [0:0]                  m_axis_tuser,   // coded
  input  logic                        cfg_we_i,
  input  logic [fcm_pkg::AlphaW-1:0]  cfg_wdata_i
);

  localparam int unsigned NumCtx   = ALPHABET ** ORDER;
  localparam int unsigned NumCells = NumCtx * ALPHABET;
  localparam int unsigned CtxW     = $clog2(NumCtx);
  localparam int unsigned CellW    = $clog2(NumCells);
  localparam int unsigned TotW     = COUNT_BITS + $clog2(ALPHABET);
  localparam int unsigned XW       = TotW + fcm_pkg::AlphaQ + 1;
  localparam int unsigned LW       = $clog2(XW) + fcm_pkg::FracW;
  localparam int unsigned FillW    = $clog2(ORDER + 1);
  localparam int unsigned SymW     = fcm_pkg::SymW;

  fcm_pkg::fcm_state_e state_q, state_d;

  logic [fcm_pkg::AlphaW-1:0] alpha_q;
  logic [SymW-1:0]            hist_q [ORDER];
  logic [SymW-1:0]            hist_d [ORDER];
  logic [FillW-1:0]           fill_q, fill_d;
  logic [CtxW-1:0]            ctx_q, ctx_d;
  logic [CellW-1:0]           clr_q, clr_d;
  logic [CellW-1:0]           cell_q, cell_d;
  logic [CtxW-1:0]            ctxa_q, ctxa_d;
  logic                       op_q, op_d;
  logic [fcm_pkg::SumW-1:0]   sum_q, sum_d;
  logic [fcm_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       coded_q, coded_d;
  logic [fcm_pkg::CostW-1:0]  cost_q, cost_d;
  logic [XW-1:0]              den_q, den_d;
  logic [XW-1:0]              num_d;
  logic [LW-1:0]              ln_q, ln_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_coded_q;
  logic [fcm_pkg::CostW-1:0]  out_cost_q;
  logic [fcm_pkg::SumW-1:0]   out_sum_q;
  logic [fcm_pkg::CntW-1:0]   out_cnt_q;

  // input fields
  logic            in_op, in_first;
  logic [SymW-1:0] in_sym;
  logic            sym_ok;
  logic [CellW-1:0] cell_new;

  // table ports
  logic                  cnt_we, tot_we;
  logic [CellW-1:0]      cnt_waddr;
  logic [CtxW-1:0]       tot_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [TotW-1:0]       tot_wdata, tot_rdata;

  // log unit
  logic          lg_start, lg_done;
  logic [XW-1:0] lg_x;
  logic [LW-1:0] lg_l;
  logic [LW-1:0] diff;
  logic [fcm_pkg::CostW-1:0] cost_sat;
  logic [fcm_pkg::CostW-1:0] cost_new;
  logic [fcm_pkg::SumW:0]    sum_add;

  assign in_op    = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_sym   = s_axis_tdata[SymW-1:0];
  assign sym_ok   = (7'(in_sym) < 7'(ALPHABET));
  assign cell_new = CellW'(ctx_q) * CellW'(ALPHABET) + CellW'(in_sym);

  fcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(NumCells)) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cell_q),
    .rdata_o (cnt_rdata)
  );

  fcm_ram #(.WIDTH(TotW), .DEPTH(NumCtx)) u_totals (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .raddr_i (ctxa_q),
    .rdata_o (tot_rdata)
  );

  fcm_log2 #(.XW(XW)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .x_i     (lg_x),
    .done_o  (lg_done),
    .l_o     (lg_l)
  );

  // cost from the two logs
  assign diff     = (lg_l >= ln_q) ? (lg_l - ln_q) : '0;
  assign cost_sat = (32'(diff) > 32'(fcm_pkg::CostMax)) ? fcm_pkg::CostMax
                                                        : fcm_pkg::CostW'(diff);
  // cost added to the running sum: computed cost, or the ceiling for a zero numerator
  assign cost_new = (state_q == fcm_pkg::ST_LOG_DEN) ? cost_sat : fcm_pkg::CostMax;
  assign sum_add  = {1'b0, sum_q} + (fcm_pkg::SumW + 1)'(cost_new);
  assign num_d    = (XW'(cnt_rdata) << fcm_pkg::AlphaQ) + XW'(alpha_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcm_pkg::ST_CLEAR;
      alpha_q     <= fcm_pkg::AlphaReset;
      fill_q      <= '0;
      ctx_q       <= '0;
      clr_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ctx_q       <= ctx_d;
      clr_q       <= clr_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      hist_q      <= hist_d;
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cell_q  <= cell_d;
    ctxa_q  <= ctxa_d;
    op_q    <= op_d;
    coded_q <= coded_d;
    cost_q  <= cost_d;
    den_q   <= den_d;
    ln_q    <= ln_d;
    if ((state_q == fcm_pkg::ST_RESULT) && (!out_valid_q || m_axis_tready)) begin
      out_coded_q <= coded_q;
      out_cost_q  <= cost_q;
      out_sum_q   <= sum_q;
      out_cnt_q   <= cnt_q;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ctx_d       = ctx_q;
    clr_d       = clr_q;
    hist_d      = hist_q;
    cell_d      = cell_q;
    ctxa_d      = ctxa_q;
    op_d        = op_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    coded_d     = coded_q;
    cost_d      = cost_q;
    den_d       = den_q;
    ln_d        = ln_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    cnt_we      = 1'b0;
    tot_we      = 1'b0;
    cnt_waddr   = cell_q;
    tot_waddr   = ctxa_q;
    cnt_wdata   = cnt_rdata + 1'b1;
    tot_wdata   = tot_rdata + 1'b1;
    lg_start    = 1'b0;
    lg_x        = num_d;
    s_axis_tready = 1'b0;

    case (state_q)
      // sweep both tables to zero after reset
      fcm_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        tot_we    = (32'(clr_q) < 32'(NumCtx));
        tot_waddr = clr_q[CtxW-1:0];
        tot_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (32'(clr_q) == 32'(NumCells - 1)) begin
          state_d = fcm_pkg::ST_IDLE;
        end
      end
      // take one transfer, update history and pick the path
      fcm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          coded_d = 1'b0;
          cost_d  = '0;
          op_d    = in_op;
          cell_d  = cell_new;
          ctxa_d  = ctx_q;
          state_d = fcm_pkg::ST_RESULT;
          if (sym_ok) begin
            if (in_first) begin
              sum_d = '0;
              cnt_d = '0;
            end
            if (in_first || (32'(fill_q) < 32'(ORDER))) begin
              fill_d = in_first ? FillW'(1) : fill_q + 1'b1;
            end else begin
              state_d = fcm_pkg::ST_READ;
            end
            for (int i = 0; i + 1 < ORDER; i++) begin
              hist_d[i] = hist_q[i+1];
            end
            hist_d[ORDER-1] = in_sym;
            ctx_d = CtxW'(cell_new - CellW'(hist_q[0]) * CellW'(NumCtx));
          end
        end
      end
      // table read in flight
      fcm_pkg::ST_READ: begin
        state_d = fcm_pkg::ST_UPDATE;
      end
      // train write-back, or operands for the cost
      fcm_pkg::ST_UPDATE: begin
        if (op_q == fcm_pkg::OpTrain) begin
          cnt_we  = (cnt_rdata != {COUNT_BITS{1'b1}});
          tot_we  = cnt_we;
          state_d = fcm_pkg::ST_RESULT;
        end else begin
          den_d   = (XW'(tot_rdata) << fcm_pkg::AlphaQ)
                    + XW'(alpha_q) * XW'(ALPHABET);
          coded_d = 1'b1;
          cnt_d   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
          if (num_d == '0) begin
            cost_d  = fcm_pkg::CostMax;
            sum_d   = sum_add[fcm_pkg::SumW] ? '1 : sum_add[fcm_pkg::SumW-1:0];
            state_d = fcm_pkg::ST_RESULT;
          end else begin
            lg_start = 1'b1;
            lg_x     = num_d;
            state_d  = fcm_pkg::ST_LOG_NUM;
          end
        end
      end
      // log2 of the numerator
      fcm_pkg::ST_LOG_NUM: begin
        if (lg_done) begin
          ln_d     = lg_l;
          lg_start = 1'b1;
          lg_x     = den_q;
          state_d  = fcm_pkg::ST_LOG_DEN;
        end
      end
      // log2 of the denominator, then cost and running sum
      fcm_pkg::ST_LOG_DEN: begin
        if (lg_done) begin
          cost_d  = cost_sat;
          sum_d   = sum_add[fcm_pkg::SumW] ? '1 : sum_add[fcm_pkg::SumW-1:0];
          state_d = fcm_pkg::ST_RESULT;
        end
      end
      // hand the result to the output register
      fcm_pkg::ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = fcm_pkg::ST_IDLE;
        end
      end
      default: state_d = fcm_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_coded_q;
  assign m_axis_tdata  = {3'b000, out_cnt_q, out_sum_q, out_cost_q};

endmodule
